[sv/tlb_pkg.sv]
package tlb_pkg;

   // Transaction field widths
   localparam int OPCODE_W   = 2;
   localparam int PID_W      = 16;
   localparam int ADDR_W     = 32;
   localparam int FRAME_W    = 20;
   localparam int BASE_W     = 36;
   localparam int SLOT_W     = 6;
   localparam int STAMP_W    = 32;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FILL   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT       = 4'd1;

   // Register reset values and limits
   localparam logic               MODE_FIFO   = 1'b0;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
   localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 5'd16;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec_lookup;
      logic exec_fill;
      logic exec_flush;
      logic scan_start;
      logic scan_step;
      logic fill_lru;
      logic result_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                need_lru;
      logic                scan_done;
      logic                out_free;
   } status_type;

endpackage

[sv/tlb_req_if.sv]
interface tlb_req_if import tlb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [PID_W-1:0]    pid;
   logic [ADDR_W-1:0]   logical_address;
   logic [FRAME_W-1:0]  frame;

   modport source (output valid, output opcode, output pid, output logical_address,
                   output frame, input ready);
   modport sink (input valid, input opcode, input pid, input logical_address,
                 input frame, output ready);
endinterface

[sv/tlb_rsp_if.sv]
interface tlb_rsp_if import tlb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [FRAME_W-1:0] frame_out;
   logic [BASE_W-1:0]  frame_base;
   logic [SLOT_W-1:0]  slot;

   modport source (output valid, output hit, output frame_out, output frame_base,
                   output slot, input ready);
   modport sink (input valid, input hit, input frame_out, input frame_base,
                 input slot, output ready);
endinterface

[sv/tlb_csr_if.sv]
interface tlb_csr_if import tlb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/tlb_fifo_lru_translation.sv]
// Fully associative TLB, tagged by pid and page number.
// req_chan: one transaction per operation (lookup, fill, flush; opcode 3 is a no-op).
// rsp_chan: exactly one result transaction for each request, in request order.
// csr_chan: register writes (0 replacement mode, 1 page shift); ready whenever reset
//   is low. The user must write only while no transaction is in flight; the block has no check for this.
// Sequencing: a request is captured, executed, then its result is loaded into the
//   output register; a new request is taken in the cycle the previous result is
//   loaded. A fill into a full TLB in LRU mode scans the use stamps one entry a
//   cycle through the stamp memory read port before the replacement write.
// Reset: all entries invalid, use counter and FIFO pointer zero, FIFO mode,
//   page shift 12. No clearing pass; requests are taken right after reset.
// Stall: a result waits in the output register while rsp_chan.ready is low; one
//   more request is accepted and executed meanwhile, then req_chan.ready stays
//   low until the output register frees.
module tlb_fifo_lru_translation import tlb_pkg::*; #(
   parameter int TLB_ENTRIES = 16
) (
   input logic       clock,
   input logic       reset,
   tlb_req_if.sink   req_chan,
   tlb_rsp_if.source rsp_chan,
   tlb_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = !reset;

   tlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlb_dpath #(
      .TLB_ENTRIES (TLB_ENTRIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_chan.opcode),
      .req_pid             (req_chan.pid),
      .req_logical_address (req_chan.logical_address),
      .req_frame           (req_chan.frame),
      .csr_write           (csr_chan.valid),
      .csr_index           (csr_chan.index),
      .csr_data            (csr_chan.data),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_hit             (rsp_chan.hit),
      .rsp_frame_out       (rsp_chan.frame_out),
      .rsp_frame_base      (rsp_chan.frame_base),
      .rsp_slot            (rsp_chan.slot)
   );

endmodule

[sv/tlb_ctrl.sv]
module tlb_ctrl import tlb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_VICT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // New transaction taken when idle, or when the finishing one hands off its result
   always_comb begin
      req_ready = !reset &&
                  ((state_ff == ST_IDLE) || ((state_ff == ST_DONE) && status.out_free));
   end

   // Sequencing of one transaction
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (status.opcode)
               OP_LOOKUP: cmd.exec_lookup = 1'b1;
               OP_FILL: begin
                  if (status.need_lru) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else begin
                     cmd.exec_fill = 1'b1;
                  end
               end
               OP_FLUSH: cmd.exec_flush = 1'b1;
               default: ;
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_VICT;
            end
         end
         ST_VICT: begin
            cmd.fill_lru = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register is only overwritten once its previous transaction has left
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> status.out_free)
      else $error("result loaded while output register still occupied");

   // End of the victim scan always leads to the replacement write
   a_scan_to_vict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && status.scan_done |=> cmd.fill_lru)
      else $error("victim scan finished without a replacement write");

   // A transaction is only captured on an accepting edge
   a_capture_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> req_ready)
      else $error("transaction captured while not ready");

endmodule

[sv/tlb_dpath.sv]
module tlb_dpath import tlb_pkg::*; #(
   parameter int TLB_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [PID_W-1:0]      req_pid,
   input  logic [ADDR_W-1:0]     req_logical_address,
   input  logic [FRAME_W-1:0]    req_frame,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [FRAME_W-1:0]    rsp_frame_out,
   output logic [BASE_W-1:0]     rsp_frame_base,
   output logic [SLOT_W-1:0]     rsp_slot
);

   localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TLB_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

   // Configuration registers
   logic               mode_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] eff_shift;

   // Captured transaction
   logic [OPCODE_W-1:0] op_ff;
   logic [PID_W-1:0]    pid_ff;
   logic [ADDR_W-1:0]   page_ff;
   logic [FRAME_W-1:0]  frame_ff;

   // Tag lanes
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [PID_W-1:0]       entry_pid_ff  [TLB_ENTRIES];
   logic [ADDR_W-1:0]      entry_page_ff [TLB_ENTRIES];

   // Frame and use stamp memories
   logic [FRAME_W-1:0] frame_mem [TLB_ENTRIES];
   logic [STAMP_W-1:0] stamp_mem [TLB_ENTRIES];
   logic [FRAME_W-1:0] frame_rd_ff;
   logic [STAMP_W-1:0] stamp_rd_ff;

   // Replacement state
   logic [STAMP_W-1:0] use_ff;
   logic [IDX_W-1:0]   fifo_ptr_ff;
   logic [CNT_W-1:0]   scan_idx_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   // Per-transaction results and output register
   logic               hit_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic               out_valid_ff;
   logic               out_hit_ff;
   logic [FRAME_W-1:0] out_frame_ff;
   logic [BASE_W-1:0]  out_base_ff;
   logic [SLOT_W-1:0]  out_slot_ff;

   // Combinational terms
   logic [TLB_ENTRIES-1:0] pid_match;
   logic [TLB_ENTRIES-1:0] match;
   logic                   any_hit;
   logic [IDX_W-1:0]       hit_idx;
   logic                   any_empty;
   logic [IDX_W-1:0]       empty_idx;
   logic [IDX_W-1:0]       fill_target;
   logic [STAMP_W-1:0]     new_stamp;
   logic                   stamp_we;
   logic [IDX_W-1:0]       stamp_idx;
   logic                   entry_we;
   logic [IDX_W-1:0]       entry_idx;
   logic                   scan_rd_ok;
   logic [BASE_W-1:0]      base_val;

   assign eff_shift = (shift_ff > MAX_SHIFT) ? MAX_SHIFT : shift_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FIFO;
         shift_ff <= SHIFT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REPLACEMENT_MODE: mode_ff  <= csr_data[0];
            CSR_PAGE_SHIFT:       shift_ff <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture transaction; page number split off here
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         pid_ff   <= req_pid;
         page_ff  <= req_logical_address >> eff_shift;
         frame_ff <= req_frame;
      end
   end

   // Parallel tag compare and priority encoders (lowest index wins)
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         pid_match[i] = (entry_pid_ff[i] == pid_ff);
         match[i]     = valid_ff[i] && pid_match[i] && (entry_page_ff[i] == page_ff);
      end
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            empty_idx = IDX_W'(i);
         end
      end
      any_hit   = |match;
      any_empty = ~&valid_ff;
   end

   assign fill_target = any_empty ? empty_idx : fifo_ptr_ff;
   assign new_stamp   = use_ff + STAMP_W'(1);
   assign stamp_we    = (cmd.exec_lookup && any_hit) || cmd.exec_fill || cmd.fill_lru;
   assign entry_we    = cmd.exec_fill || cmd.fill_lru;
   assign entry_idx   = cmd.exec_fill ? fill_target : best_idx_ff;
   assign stamp_idx   = cmd.exec_lookup ? hit_idx : entry_idx;
   assign scan_rd_ok  = (scan_idx_ff < CNT_W'(TLB_ENTRIES));

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.exec_flush) begin
            valid_ff <= valid_ff & ~pid_match;
         end
         if (entry_we) begin
            valid_ff[entry_idx] <= 1'b1;
         end
      end
   end

   // Tag lanes
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_pid_ff[entry_idx]  <= pid_ff;
         entry_page_ff[entry_idx] <= page_ff;
      end
   end

   // Frame memory: write on fill, registered read on lookup hit
   always_ff @(posedge clock) begin
      if (entry_we) begin
         frame_mem[entry_idx] <= frame_ff;
      end
      if (cmd.exec_lookup && any_hit) begin
         frame_rd_ff <= frame_mem[hit_idx];
      end
   end

   // Stamp memory: write on hit or fill, registered read during the scan
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_idx] <= new_stamp;
      end
      if (cmd.scan_step && scan_rd_ok) begin
         stamp_rd_ff <= stamp_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // Use counter, FIFO pointer and scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff      <= '0;
         fifo_ptr_ff <= '0;
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         if (stamp_we) begin
            use_ff <= new_stamp;
         end
         if (cmd.exec_fill && !any_empty) begin
            fifo_ptr_ff <= (fifo_ptr_ff == LAST_IDX) ? '0 : fifo_ptr_ff + IDX_W'(1);
         end
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            scan_idx_ff <= scan_rd_ok ? scan_idx_ff + CNT_W'(1) : scan_idx_ff;
            rd_valid_ff <= scan_rd_ok;
            rd_idx_ff   <= scan_idx_ff[IDX_W-1:0];
         end
      end
   end

   // Running minimum; strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         if ((rd_idx_ff == '0) || (stamp_rd_ff < best_stamp_ff)) begin
            best_stamp_ff <= stamp_rd_ff;
            best_idx_ff   <= rd_idx_ff;
         end
      end
   end

   // Per-transaction result fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_ff  <= 1'b0;
         slot_ff <= '0;
      end else if (cmd.exec_lookup) begin
         hit_ff  <= any_hit;
         slot_ff <= any_hit ? hit_idx : '0;
      end else if (entry_we) begin
         slot_ff <= entry_idx;
      end
   end

   assign base_val = BASE_W'(frame_rd_ff) << eff_shift;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         out_hit_ff   <= hit_ff;
         out_frame_ff <= hit_ff ? frame_rd_ff : '0;
         out_base_ff  <= hit_ff ? base_val : '0;
         out_slot_ff  <= SLOT_W'(slot_ff);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_frame_out  = out_frame_ff;
   assign rsp_frame_base = out_base_ff;
   assign rsp_slot       = out_slot_ff;

   always_comb begin
      status.opcode    = op_ff;
      status.need_lru  = mode_ff && !any_empty;
      status.scan_done = rd_valid_ff && (rd_idx_ff == LAST_IDX);
      status.out_free  = !out_valid_ff || rsp_ready;
   end

   // At most one state-changing command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec_lookup, cmd.exec_fill, cmd.exec_flush, cmd.scan_start,
                cmd.scan_step, cmd.fill_lru}))
      else $error("conflicting datapath commands");

   // A fill leaves the written slot valid
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      entry_we |=> valid_ff[slot_ff])
      else $error("filled slot not valid");

   // A flush leaves no valid entry of that pid
   a_flush_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_flush |=> ((valid_ff & pid_match) == '0))
      else $error("flushed pid still has a valid entry");

endmodule
